### hdl/lwkd_pkg.sv
package lwkd_pkg;

  // Field widths fixed by the interface
  localparam int SYM_W  = 8;
  localparam int TGT_W  = 9;
  localparam int BEST_W = 11;

  // Target after reset
  localparam logic [TGT_W-1:0] TARGET_RESET = 9'd1;

  // Per-request sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_HIST,
    S_CNT,
    S_OUT
  } lwkd_state_t;

endpackage

### hdl/lwkd_if.sv
// Request channel: one string byte per request
interface lwkd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lwkd_pkg::SYM_W-1:0] symbol;
  logic                       end_of_string;

  modport source (output valid, symbol, end_of_string, input ready);
  modport sink   (input valid, symbol, end_of_string, output ready);
endinterface

// Result channel: one result per request
interface lwkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lwkd_pkg::BEST_W-1:0] best_length;
  logic                        found;
  logic                        overflow;
  logic                        final_res;

  modport source (output valid, best_length, found, overflow, final_res, input ready);
  modport sink   (input valid, best_length, found, overflow, final_res, output ready);
endinterface

// Configuration write channel: distinct target only
interface lwkd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lwkd_pkg::TGT_W-1:0] distinct_target;

  modport source (output valid, distinct_target, input ready);
  modport sink   (input valid, distinct_target, output ready);
endinterface

### hdl/lwkd_ram.sv
module lwkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/longest_window_k_distinct_core.sv
// Longest window holding exactly k distinct byte values.
//
// Channels: cfg_ch writes the distinct target k (always ready, write only while
// idle). in_ch takes one byte per request with an end_of_string mark; out_ch
// returns one result per request: the running best length, a found flag, an
// overflow flag (byte past MAX_LEN, ignored) and an echo of the end mark.
//
// Steps: a request is accepted, its count is updated and its result is loaded
// into the result register; each byte dropped from the window start adds a
// history read, then a count read-modify-write. A byte past MAX_LEN goes from
// acceptance straight to the result load. Each byte is dropped at most once;
// the extra steps come from the registered read ports of the history and count
// memories. The next request is taken once the current one has reached the
// result register, even while it still waits.
//
// Reset (synchronous, rst_n low) sets k to 1 and empties the window; the
// per-symbol counts are cleared at once through their valid bits, so no
// clearing pass is needed. An end mark clears the string state the same way.
// When the receiver stalls, the result register holds and the block waits in
// its result state; no result is lost.
module longest_window_k_distinct_core #(
  parameter int MAX_LEN      = 1024,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  lwkd_cfg_if.sink         cfg_ch,
  lwkd_in_if.sink          in_ch,
  lwkd_out_if.source       out_ch
);

  localparam int PW  = $clog2(MAX_LEN + 1);
  localparam int HAW = $clog2(MAX_LEN);
  localparam int SAW = $clog2(SYMBOL_COUNT);
  localparam int TW  = lwkd_pkg::TGT_W;
  localparam int BW  = lwkd_pkg::BEST_W;
  localparam int SW  = lwkd_pkg::SYM_W;
  localparam int SYM_VALUES = 1 << SW;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

  // Build the table that reduces each byte value modulo the alphabet size
  function automatic logic [SYM_VALUES*SAW-1:0] build_sym_tab();
    logic [SYM_VALUES*SAW-1:0] tab;
    tab = '0;
    for (int i = 0; i < SYM_VALUES; i++) begin
      tab[i*SAW +: SAW] = SAW'(i % SYMBOL_COUNT);
    end
    return tab;
  endfunction

  localparam logic [SYM_VALUES*SAW-1:0] SYM_TAB = build_sym_tab();

  lwkd_pkg::lwkd_state_t state_r, state_nxt;

  logic [TW-1:0]           target_r;
  logic [TW-1:0]           distinct_r, distinct_nxt, dist_step;
  logic [PW-1:0]           ws_r, ws_nxt, ws_step;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [PW-1:0]           best_r, best_nxt, len;
  logic                    found_r, found_nxt;
  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;

  logic [SAW-1:0] sym_r, old_r, cnt_sel, cnt_raddr, sym_red, hist_rdata;
  logic           last_r;

  logic [PW-1:0]  cnt_rdata, cnt_cur, cnt_wdata;
  logic           cnt_we, hist_we;

  logic [PW-1:0]  res_best_r, res_best_nxt;
  logic           res_found_r, res_found_nxt;
  logic           res_over_r, res_over_nxt;
  logic           res_last_r, res_last_nxt;

  logic [BW-1:0]  out_best_r;
  logic           out_found_r, out_over_r, out_final_r, out_valid_r;

  logic           in_acc, out_load, drop_more, qualify, in_over;

  // Handshakes
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == lwkd_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && (state_r == lwkd_pkg::S_IDLE);
  assign in_over      = (pos_r >= MAX_POS);
  assign out_load     = (state_r == lwkd_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  assign sym_red = SYM_TAB[int'(in_ch.symbol) * SAW +: SAW];

  // History of the string
  assign hist_we = in_acc && !in_over;

  lwkd_ram #(.WIDTH(SAW), .DEPTH(MAX_LEN)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_r[HAW-1:0]),
    .wdata (sym_red),
    .raddr (ws_nxt[HAW-1:0]),
    .rdata (hist_rdata)
  );

  // Per-symbol occurrence counts
  always_comb begin
    case (state_r)
      lwkd_pkg::S_IDLE: cnt_raddr = sym_red;
      lwkd_pkg::S_HIST: cnt_raddr = hist_rdata;
      default:          cnt_raddr = sym_r;
    endcase
  end

  lwkd_ram #(.WIDTH(PW), .DEPTH(SYMBOL_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_sel),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Add or drop one byte: count update and window bookkeeping
  always_comb begin
    cnt_sel = (state_r == lwkd_pkg::S_CNT) ? old_r : sym_r;
    cnt_cur = valid_r[cnt_sel] ? cnt_rdata : '0;
    if (state_r == lwkd_pkg::S_CNT) begin
      cnt_wdata = cnt_cur - PW'(1);
      cnt_we    = (cnt_cur != '0);
      dist_step = ((cnt_cur == PW'(1)) && (distinct_r != '0)) ?
                  distinct_r - TW'(1) : distinct_r;
      ws_step   = ws_r + PW'(1);
    end else begin
      cnt_wdata = cnt_cur + PW'(1);
      cnt_we    = (state_r == lwkd_pkg::S_ADD);
      dist_step = (cnt_cur == '0) ? distinct_r + TW'(1) : distinct_r;
      ws_step   = ws_r;
    end
    drop_more = (dist_step > target_r) && (ws_step <= pos_r);
    qualify   = (dist_step == target_r);
    len       = pos_r + PW'(1) - ws_step;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      lwkd_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_over ? lwkd_pkg::S_OUT : lwkd_pkg::S_ADD;
        end
      end
      lwkd_pkg::S_ADD, lwkd_pkg::S_CNT: begin
        state_nxt = drop_more ? lwkd_pkg::S_HIST : lwkd_pkg::S_OUT;
      end
      lwkd_pkg::S_HIST: state_nxt = lwkd_pkg::S_CNT;
      lwkd_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = lwkd_pkg::S_IDLE;
        end
      end
      default: state_nxt = lwkd_pkg::S_IDLE;
    endcase
  end

  // Window state and pending result
  always_comb begin
    distinct_nxt  = distinct_r;
    ws_nxt        = ws_r;
    pos_nxt       = pos_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    valid_nxt     = valid_r;
    res_best_nxt  = res_best_r;
    res_found_nxt = res_found_r;
    res_over_nxt  = res_over_r;
    res_last_nxt  = res_last_r;
    unique case (state_r) inside
      lwkd_pkg::S_IDLE: begin
        // Byte past the end of the history: answer with the unchanged best
        if (in_acc && in_over) begin
          res_best_nxt  = best_r;
          res_found_nxt = found_r;
          res_over_nxt  = 1'b1;
          res_last_nxt  = in_ch.end_of_string;
          if (in_ch.end_of_string) begin
            distinct_nxt = '0;
            ws_nxt       = '0;
            pos_nxt      = '0;
            best_nxt     = '0;
            found_nxt    = 1'b0;
            valid_nxt    = '0;
          end
        end
      end
      lwkd_pkg::S_ADD, lwkd_pkg::S_CNT: begin
        if (state_r == lwkd_pkg::S_ADD) begin
          valid_nxt[sym_r] = 1'b1;
        end
        distinct_nxt = dist_step;
        ws_nxt       = ws_step;
        // Window settled: offer its length and advance the position
        if (!drop_more) begin
          if (qualify) begin
            if (!found_r || (len > best_r)) begin
              best_nxt = len;
            end
            found_nxt = 1'b1;
          end
          pos_nxt       = pos_r + PW'(1);
          res_best_nxt  = best_nxt;
          res_found_nxt = found_nxt;
          res_over_nxt  = 1'b0;
          res_last_nxt  = last_r;
          if (last_r) begin
            distinct_nxt = '0;
            ws_nxt       = '0;
            pos_nxt      = '0;
            best_nxt     = '0;
            found_nxt    = 1'b0;
            valid_nxt    = '0;
          end
        end
      end
      lwkd_pkg::S_HIST, lwkd_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lwkd_pkg::S_IDLE;
      target_r    <= lwkd_pkg::TARGET_RESET;
      distinct_r  <= '0;
      ws_r        <= '0;
      pos_r       <= '0;
      best_r      <= '0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      distinct_r <= distinct_nxt;
      ws_r       <= ws_nxt;
      pos_r      <= pos_nxt;
      best_r     <= best_nxt;
      found_r    <= found_nxt;
      valid_r    <= valid_nxt;
      if (cfg_ch.valid) begin
        target_r <= cfg_ch.distinct_target;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_best_r  <= res_best_nxt;
    res_found_r <= res_found_nxt;
    res_over_r  <= res_over_nxt;
    res_last_r  <= res_last_nxt;
    if (in_acc) begin
      sym_r  <= sym_red;
      last_r <= in_ch.end_of_string;
    end
    if (state_r == lwkd_pkg::S_HIST) begin
      old_r <= hist_rdata;
    end
    if (out_load) begin
      out_best_r  <= BW'(res_best_r);
      out_found_r <= res_found_r;
      out_over_r  <= res_over_r;
      out_final_r <= res_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_length = out_best_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.overflow    = out_over_r;
  assign out_ch.final_res   = out_final_r;

`ifndef SYNTHESIS
  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= TW'(SYMBOL_COUNT))
    else $error("distinct count exceeds alphabet size");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("position beyond history depth");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lwkd_pkg::S_IDLE) |-> (ws_r <= pos_r))
    else $error("window start passed position while idle");

  a_best_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (best_r == '0))
    else $error("best length set without a qualifying window");

  a_add_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_over) |=> (state_r == lwkd_pkg::S_ADD))
    else $error("accepted byte did not enter the count update");
`endif

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 1024;
  localparam int SYMBOL_COUNT = 256;
  localparam int TGT_UNMET    = 511;  // all target bits set, never reachable

  // One result as the block should return it
  typedef struct packed {
    logic [lwkd_pkg::BEST_W-1:0] best_length;
    logic                        found;
    logic                        overflow;
    logic                        final_res;
  } window_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  lwkd_cfg_if cfg_ch();
  lwkd_in_if  in_ch();
  lwkd_out_if out_ch();

  longest_window_k_distinct_core #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Predicted string state
  int unsigned    sym_count[SYMBOL_COUNT];
  logic [7:0]     history[MAX_LEN];
  int unsigned    n_distinct;
  int unsigned    win_start;
  int unsigned    pos;
  int unsigned    best_len;
  bit             found_any;
  int unsigned    target;

  window_answer_t expected_answers[$];
  int unsigned    send_idle;
  int unsigned    recv_stall;
  int unsigned    bytes_sent;
  int             errors;

  function automatic void clear_string();
    foreach (sym_count[i]) sym_count[i] = 0;
    n_distinct = 0;
    win_start  = 0;
    pos        = 0;
    best_len   = 0;
    found_any  = 1'b0;
  endfunction

  // Add one byte to the window, shrink it to the target and offer its length
  function automatic window_answer_t longest_window_step(logic [7:0] sym, logic eos);
    window_answer_t ans;
    int unsigned    old;
    int unsigned    len;
    ans.overflow = 1'b0;
    if (pos >= MAX_LEN) begin
      ans.overflow = 1'b1;
    end else begin
      history[pos] = sym;
      if (sym_count[sym] == 0) n_distinct++;
      sym_count[sym]++;
      while (n_distinct > target && win_start <= pos) begin
        old = 32'(history[win_start % MAX_LEN]);
        if (sym_count[old] > 0) begin
          sym_count[old]--;
          if (sym_count[old] == 0 && n_distinct > 0) n_distinct--;
        end
        win_start++;
      end
      if (n_distinct == target) begin
        len = pos + 1 - win_start;
        if (!found_any || len > best_len) best_len = len;
        found_any = 1'b1;
      end
      pos++;
    end
    ans.best_length = lwkd_pkg::BEST_W'(best_len);
    ans.found       = found_any;
    ans.final_res   = eos;
    if (eos) clear_string();
    return ans;
  endfunction

  // Offer one byte request, predict its answer and hold until accepted
  task automatic send_byte(logic [7:0] sym, logic eos);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.symbol        <= sym;
    in_ch.end_of_string <= eos;
    expected_answers.push_back(longest_window_step(sym, eos));
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Stop requesting and hold until every predicted answer has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_answers.size() != 0);
  endtask

  task automatic write_target(int unsigned value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.distinct_target <= lwkd_pkg::TGT_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    target = 32'(lwkd_pkg::TGT_W'(value));
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle  = send_pct;
    recv_stall = recv_pct;
  endtask

  // Reset target of one, plus a one-byte string
  task automatic test_reset_target();
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Extreme byte values, the empty-window target and unreachable targets
  task automatic test_target_extremes();
    drain_results();
    write_target(2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();
    write_target(0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    drain_results();
    write_target(TGT_UNMET);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain_results();
    write_target(SYMBOL_COUNT);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
  endtask

  // Lower the target part way through a string
  task automatic test_mid_string_target();
    drain_results();
    write_target(3);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd4, 1'b0);
    drain_results();
    write_target(1);
    send_byte(8'd2, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd5, 1'b1);
  endtask

  // Two-symbol string past MAX_LEN: full-length window, then ignored bytes
  task automatic test_overflow();
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    sym_a = 8'($urandom_range(255));
    sym_b = sym_a ^ 8'($urandom_range(1, 255));
    drain_results();
    write_target(2);
    set_idling(29, 29);
    for (int i = 0; i < MAX_LEN + 6; i++)
      send_byte($urandom_range(1) ? sym_a : sym_b, i == MAX_LEN + 5);
  endtask

  // Every byte value once in shuffled order with target 256, then the first again
  task automatic test_full_alphabet();
    logic [7:0] perm[SYMBOL_COUNT];
    logic [7:0] tmp;
    int         j;
    foreach (perm[i]) perm[i] = 8'(i);
    for (int i = SYMBOL_COUNT - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    drain_results();
    write_target(SYMBOL_COUNT);
    set_idling(0, 0);
    foreach (perm[i]) send_byte(perm[i], 1'b0);
    send_byte(perm[0], 1'b1);
  endtask

  // Strings over small random alphabets with some noise bytes
  task automatic run_random_strings(int unsigned n_items);
    int unsigned start;
    int unsigned len;
    int unsigned n_alpha;
    logic [7:0]  alpha[8];
    logic [7:0]  sym;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        case ($urandom_range(9))
          0:       write_target(0);
          1:       write_target($urandom_range(SYMBOL_COUNT));
          default: write_target($urandom_range(1, 6));
        endcase
      end
      n_alpha = $urandom_range(1, 8);
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) sym = 8'($urandom_range(255));
        else sym = alpha[$urandom_range(n_alpha - 1)];
        // Change the target part way through, with the block idle
        if (len > 1 && i == len / 2 && $urandom_range(7) == 0) begin
          drain_results();
          write_target($urandom_range(0, 6));
        end
        send_byte(sym, i == len - 1);
      end
    end
  endtask

  task automatic test_random();
    set_idling(0, 0);
    run_random_strings(25);
    set_idling(54, 0);
    run_random_strings(25);
    set_idling(0, 54);
    run_random_strings(25);
    set_idling(29, 29);
    run_random_strings(25);
  endtask

  // Check each accepted result against the oldest prediction
  initial begin
    window_answer_t exp;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $error("result with no request outstanding: best_length %0d", out_ch.best_length);
          errors++;
        end else begin
          exp = expected_answers.pop_front();
          if (out_ch.best_length !== exp.best_length) begin
            $error("best_length: expected %0d, got %0d", exp.best_length, out_ch.best_length);
            errors++;
          end
          if (out_ch.found !== exp.found) begin
            $error("found: expected %0b, got %0b", exp.found, out_ch.found);
            errors++;
          end
          if (out_ch.overflow !== exp.overflow) begin
            $error("overflow: expected %0b, got %0b", exp.overflow, out_ch.overflow);
            errors++;
          end
          if (out_ch.final_res !== exp.final_res) begin
            $error("final_res: expected %0b, got %0b", exp.final_res, out_ch.final_res);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Stimulus
  initial begin
    errors     = 0;
    bytes_sent = 0;
    target     = 32'(lwkd_pkg::TARGET_RESET);
    clear_string();
    set_idling(0, 0);
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.symbol           <= '0;
    in_ch.end_of_string    <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.distinct_target <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_target();
    test_target_extremes();
    test_mid_string_target();
    test_overflow();
    test_full_alphabet();
    test_random();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hdl/lwkd_pkg.sv
hdl/lwkd_if.sv
hdl/lwkd_ram.sv
hdl/longest_window_k_distinct_core.sv
tb/testbench.sv
